[src/assert_macros.svh]
// assertion macros shared by the queue rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define AST_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AST_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/deq_pkg.sv]
// types and constants of the double-ended queue
package deq_pkg;

  localparam int DEQ_DEPTH = 16;
  localparam int REQ_W     = 3;
  localparam int VAL_W     = 32;
  localparam int ENTRY_W   = 5;

  typedef enum logic [REQ_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SIZE       = 3'd4,
    OP_LIST       = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEND
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    op_t  op;
    logic load_mem;
    logic list_next;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic more;
  } dp_stat_t;

endpackage

[src/deq_in_if.sv]
// request channel of the queue
interface deq_in_if;
  import deq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic signed [VAL_W-1:0] push_value;

  modport source (output valid, req_type, push_value, input ready);
  modport sink (input valid, req_type, push_value, output ready);
endinterface

[src/deq_out_if.sv]
// result channel of the queue
interface deq_out_if;
  import deq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] out_value;
  logic                    has_value;
  logic [ENTRY_W-1:0]      entry_count;
  logic [1:0]              status;
  logic                    last;

  modport source (output valid, out_value, has_value, entry_count, status, last,
                  input ready);
  modport sink (input valid, out_value, has_value, entry_count, status, last,
                output ready);
endinterface

[src/deq_ctrl.sv]
// sequencer of the queue: request acceptance, memory read wait, result transfer
`include "assert_macros.svh"

module deq_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [deq_pkg::REQ_W-1:0] req_type,
  output logic                     in_ready,
  output logic                     out_valid,
  input  logic                     out_ready,
  input  deq_pkg::dp_stat_t        stat,
  output deq_pkg::dp_cmd_t         cmd
);
  import deq_pkg::*;

  ctrl_state_t state, state_next;
  op_t         op;
  logic        needs_read;

  assign op = op_t'(req_type);

  always_comb begin
    case (op) inside
      OP_POP_FRONT, OP_POP_BACK, OP_LIST: needs_read = !stat.empty;
      default:                            needs_read = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd.accept    = 1'b0;
    cmd.op        = op;
    cmd.load_mem  = 1'b0;
    cmd.list_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = needs_read ? S_READ : S_SEND;
        end
      end
      S_READ: begin
        cmd.load_mem = 1'b1;
        state_next   = S_SEND;
      end
      S_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          // list streams on: fetch the next entry after each transfer
          if (stat.more) begin
            cmd.list_next = 1'b1;
            state_next    = S_READ;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `AST_IMPL(a_excl_ready_valid, in_ready, !out_valid, "accept and result at once")
  `AST_NEXT(a_read_then_send, state == S_READ, out_valid, "read not followed by result")
  `AST_NEXT(a_idle_after_last, out_valid && out_ready && !stat.more, in_ready,
            "not ready after final transfer")

endmodule

[src/deq_dp.sv]
// datapath of the queue: slot memory, head and count, result register
`include "assert_macros.svh"

module deq_dp #(
  parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  deq_pkg::dp_cmd_t                cmd,
  input  logic signed [deq_pkg::VAL_W-1:0] push_value,
  output deq_pkg::dp_stat_t               stat,
  output logic signed [deq_pkg::VAL_W-1:0] out_value,
  output logic                            has_value,
  output logic [deq_pkg::ENTRY_W-1:0]     entry_count,
  output deq_pkg::stat_t                  status,
  output logic                            last
);
  import deq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rd_data;
  logic [IDX_W-1:0]        head;
  logic [CNT_W-1:0]        count;
  logic [IDX_W-1:0]        list_idx;
  op_t                     cur_op;

  logic             full, empty, we, is_push, is_pop;
  logic [IDX_W-1:0] front_slot, back_slot, tail_slot, next_slot, waddr, raddr;
  logic [CNT_W-1:0] idx_cnt;

  // ring position a + b, both below DEPTH
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_X) s = s - DEPTH_X;
    return s[IDX_W-1:0];
  endfunction

  assign full       = (count == CNT_FULL);
  assign empty      = (count == '0);
  assign front_slot = (head == '0) ? IDX_LAST : head - 1'b1;
  assign back_slot  = ring_add(head, count[IDX_W-1:0]);
  assign tail_slot  = ring_add(head, IDX_W'(count - 1'b1));
  assign next_slot  = ring_add(head, list_idx + 1'b1);
  assign idx_cnt    = CNT_W'(list_idx) + 1'b1;

  assign is_push = (cmd.op == OP_PUSH_FRONT) || (cmd.op == OP_PUSH_BACK);
  assign is_pop  = (cmd.op == OP_POP_FRONT) || (cmd.op == OP_POP_BACK);
  assign we      = cmd.accept && is_push && !full;
  assign waddr   = (cmd.op == OP_PUSH_FRONT) ? front_slot : back_slot;

  always_comb begin
    if (cmd.list_next) begin
      raddr = next_slot;
    end else if (cmd.op == OP_POP_BACK) begin
      raddr = tail_slot;
    end else begin
      raddr = head;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= push_value;
    end
    rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.accept) begin
      case (cmd.op)
        OP_PUSH_FRONT: begin
          if (!full) begin
            head  <= front_slot;
            count <= count + 1'b1;
          end
        end
        OP_PUSH_BACK: begin
          if (!full) count <= count + 1'b1;
        end
        OP_POP_FRONT: begin
          if (!empty) begin
            head  <= ring_add(head, IDX_W'(1));
            count <= count - 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (!empty) count <= count - 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_op      <= cmd.op;
      list_idx    <= '0;
      out_value   <= '0;
      has_value   <= 1'b0;
      last        <= 1'b1;
      status      <= ST_OK;
      entry_count <= ENTRY_W'(count);
      case (cmd.op) inside
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (full) status <= ST_FULL;
          else entry_count <= ENTRY_W'(count + 1'b1);
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (empty) status <= ST_EMPTY;
          else entry_count <= ENTRY_W'(count - 1'b1);
        end
        default: ;
      endcase
    end else if (cmd.load_mem) begin
      out_value <= rd_data;
      has_value <= 1'b1;
      status    <= ST_OK;
      last      <= (cur_op != OP_LIST) || (idx_cnt == count);
    end else if (cmd.list_next) begin
      list_idx <= list_idx + 1'b1;
    end
  end

  assign stat.empty = empty;
  assign stat.more  = !last;

  `AST_NEXT(a_push_count, cmd.accept && is_push && !full, count == $past(count) + 1'b1,
            "push did not grow the queue")
  `AST_NEXT(a_pop_count, cmd.accept && is_pop && !empty, count == $past(count) - 1'b1,
            "pop did not shrink the queue")
  `AST_IMPL(a_count_max, 1'b1, count <= CNT_FULL, "entry count above depth")

endmodule

[src/double_ended_queue.sv]
// double-ended queue of signed values in a ring of DEPTH memory slots
// push, size and unknown requests, and pop or list on an empty queue: result valid the cycle after acceptance
// pop: acceptance, then S_READ, then result valid in S_SEND (registered slot memory read)
// list: each entry valid in S_SEND after an S_READ that follows acceptance or the previous transfer
// next request accepted the cycle after the final transfer of the current one
// synchronous reset clears head and count; the slot memory is not cleared
module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
  input logic      clk,
  input logic      rst,
  deq_in_if.sink   req,
  deq_out_if.source rsp
);
  import deq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  stat_t    status;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .req_type  (req.req_type),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .push_value  (req.push_value),
    .stat        (stat),
    .out_value   (rsp.out_value),
    .has_value   (rsp.has_value),
    .entry_count (rsp.entry_count),
    .status      (status),
    .last        (rsp.last)
  );

  assign rsp.status = status;

endmodule

[bench/double_ended_queue_tb.sv]
// self-checking testbench of the double-ended queue: directed table, then biased random traffic
`timescale 1ns / 1ps

module double_ended_queue_tb;
  import deq_pkg::*;

  localparam int DEPTH          = DEQ_DEPTH;
  localparam int RANDOM_ITEMS   = 240;
  localparam int STEADY_ITEMS   = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 20;

  localparam logic [REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED_7 = 3'd7;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    has_value;
    logic [ENTRY_W-1:0]      count;
    stat_t                   status;
    logic                    last;
  } deq_result_t;

  typedef struct {
    logic [REQ_W-1:0]        op;
    logic signed [VAL_W-1:0] value;
    bit                      typed;
    deq_result_t             want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  deq_in_if  req_bus ();
  deq_out_if rsp_bus ();

  double_ended_queue #(.DEPTH(DEPTH)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the ring
  logic signed [VAL_W-1:0] ring_shadow [DEPTH];
  int unsigned             head_shadow = 0;
  int unsigned             fill_shadow = 0;

  deq_result_t rsp_due [$];
  stim_row_t   directed_rows [$];
  int          mismatch_count = 0;
  bit          steady_tail = 1'b0;

  function automatic void add_row(input logic [REQ_W-1:0] op,
                                  input logic signed [VAL_W-1:0] value,
                                  input bit typed = 1'b0,
                                  input logic signed [VAL_W-1:0] w_value = '0,
                                  input logic w_has = 1'b0,
                                  input int w_count = 0,
                                  input stat_t w_status = ST_OK);
    stim_row_t row;
    row.op             = op;
    row.value          = value;
    row.typed          = typed;
    row.want.value     = w_value;
    row.want.has_value = w_has;
    row.want.count     = ENTRY_W'(w_count);
    row.want.status    = w_status;
    row.want.last      = 1'b1;
    directed_rows.push_back(row);
  endfunction

  // applies one request to the shadow ring and queues the results it must produce
  function automatic void deque_predict(input logic [REQ_W-1:0] op,
                                        input logic signed [VAL_W-1:0] value);
    deq_result_t r;
    int unsigned k;
    bit          listed;
    listed      = 1'b0;
    r.value     = '0;
    r.has_value = 1'b0;
    r.status    = ST_OK;
    r.last      = 1'b1;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (fill_shadow >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (op == OP_PUSH_FRONT) begin
            head_shadow = (head_shadow + DEPTH - 1) % DEPTH;
            ring_shadow[head_shadow] = value;
          end else begin
            ring_shadow[(head_shadow + fill_shadow) % DEPTH] = value;
          end
          fill_shadow++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (fill_shadow == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.has_value = 1'b1;
          if (op == OP_POP_FRONT) begin
            r.value     = ring_shadow[head_shadow];
            head_shadow = (head_shadow + 1) % DEPTH;
          end else begin
            r.value = ring_shadow[(head_shadow + fill_shadow - 1) % DEPTH];
          end
          fill_shadow--;
        end
      end
      OP_LIST: begin
        // one transfer per stored entry, front to back
        for (k = 0; k < fill_shadow; k++) begin
          r.value     = ring_shadow[(head_shadow + k) % DEPTH];
          r.has_value = 1'b1;
          r.count     = ENTRY_W'(fill_shadow);
          r.last      = (k + 1 == fill_shadow);
          rsp_due.push_back(r);
          listed = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!listed) begin
      r.count = ENTRY_W'(fill_shadow);
      rsp_due.push_back(r);
    end
  endfunction

  task automatic send_request(input logic [REQ_W-1:0] op,
                              input logic signed [VAL_W-1:0] value,
                              input bit typed,
                              input deq_result_t want);
    if (!steady_tail && $urandom_range(0, 4) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    req_bus.valid      <= 1'b1;
    req_bus.req_type   <= op;
    req_bus.push_value <= value;
    do @(posedge clk); while (!req_bus.ready);
    deque_predict(op, value);
    if (typed) begin
      void'(rsp_due.pop_back());
      rsp_due.push_back(want);
    end
  endtask

  // hold the request side until every queued result has come out
  task automatic drain_wait();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (rsp_due.size() != 0);
  endtask

  // result side: random stall bursts, none in the tail
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!steady_tail && stall_left == 0 && $urandom_range(0, 9) == 0)
        stall_left = $urandom_range(1, 13);
      if (stall_left > 0) begin
        rsp_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    deq_result_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (rsp_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: value %0d has %0b count %0d status %0d last %0b",
                   rsp_bus.out_value, rsp_bus.has_value, rsp_bus.entry_count,
                   rsp_bus.status, rsp_bus.last);
      end else begin
        want = rsp_due.pop_front();
        if (rsp_bus.out_value !== want.value || rsp_bus.has_value !== want.has_value ||
            rsp_bus.entry_count !== want.count || rsp_bus.status !== want.status ||
            rsp_bus.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected value %0d has %0b count %0d status %0d last %0b, %s",
                     want.value, want.has_value, want.count, want.status, want.last,
                     $sformatf("got value %0d has %0b count %0d status %0d last %0b",
                               rsp_bus.out_value, rsp_bus.has_value, rsp_bus.entry_count,
                               rsp_bus.status, rsp_bus.last));
        end
      end
    end
  end

  // cycles with no transfer on either side
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("double_ended_queue test failed");
    $finish;
  end

  initial begin
    int                      k;
    int                      roll;
    int                      push_pct;
    int                      mode_left;
    logic [REQ_W-1:0]        op;
    logic signed [VAL_W-1:0] value;
    deq_result_t             no_want;

    no_want = '0;
    req_bus.valid      <= 1'b0;
    req_bus.req_type   <= OP_SIZE;
    req_bus.push_value <= '0;

    // empty-queue corners
    add_row(OP_POP_FRONT, 32'sd5, 1'b1, '0, 1'b0, 0, ST_EMPTY);
    add_row(OP_POP_BACK, -32'sd1, 1'b1, '0, 1'b0, 0, ST_EMPTY);
    add_row(OP_LIST, '0, 1'b1, '0, 1'b0, 0, ST_OK);
    add_row(OP_SIZE, '0, 1'b1, '0, 1'b0, 0, ST_OK);
    add_row(REQ_UNUSED_6, VAL_MAX, 1'b1, '0, 1'b0, 0, ST_OK);
    // fill to the brim from both ends
    for (k = 0; k < DEPTH; k++) begin
      case (k)
        0, 15:   value = VAL_MAX;
        1, 14:   value = VAL_MIN;
        2:       value = '0;
        3:       value = '1;
        default: value = $urandom();
      endcase
      add_row(k[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, value, 1'b1, '0, 1'b0, k + 1, ST_OK);
    end
    add_row(OP_PUSH_BACK, 32'sh1234_5678, 1'b1, '0, 1'b0, DEPTH, ST_FULL);
    add_row(OP_LIST, '0);
    add_row(OP_POP_FRONT, '0);
    add_row(OP_POP_BACK, '0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].value,
                   directed_rows[i].typed, directed_rows[i].want);
    drain_wait();

    push_pct  = 60;
    mode_left = $urandom_range(15, 40);
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      steady_tail = (k >= RANDOM_ITEMS - STEADY_ITEMS);
      // alternate filling and draining spells so full and wrapped states recur
      if (mode_left == 0) begin
        push_pct  = (push_pct > 40) ? 20 : 60;
        mode_left = $urandom_range(15, 40);
      end
      mode_left--;
      roll = $urandom_range(0, 99);
      if (roll < 3)
        op = $urandom_range(0, 1) ? REQ_UNUSED_7 : REQ_UNUSED_6;
      else if (roll < 9)
        op = OP_LIST;
      else if (roll < 14)
        op = OP_SIZE;
      else if (roll < 14 + push_pct)
        op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      else
        op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      case ($urandom_range(0, 7))
        0:       value = VAL_MAX;
        1:       value = VAL_MIN;
        2:       value = '0;
        3:       value = '1;
        default: value = $urandom();
      endcase
      send_request(op, value, 1'b0, no_want);
      if (k == RANDOM_ITEMS / 2)
        drain_wait();
    end

    req_bus.valid <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("double_ended_queue test passed");
    else
      $display("double_ended_queue test failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/deq_pkg.sv
src/deq_in_if.sv
src/deq_out_if.sv
src/deq_ctrl.sv
src/deq_dp.sv
src/double_ended_queue.sv
bench/double_ended_queue_tb.sv
